/* rtl/lcdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lcdr_pkg;

  localparam int unsigned N_WORDS_DEF    = 1024;
  localparam int unsigned COUNT_BITS     = 8;
  localparam int unsigned WEIGHT_BITS    = 32;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned ACC_BITS       = 48;
  localparam int unsigned RATE_BITS      = 16;
  localparam int unsigned EPROD_BITS     = WEIGHT_BITS + COUNT_BITS + 1;
  localparam int unsigned UPROD_BITS     = WEIGHT_BITS + RATE_BITS + 1;
  localparam int unsigned HI_BITS        = UPROD_BITS - FRAC_BITS;
  localparam int unsigned TERM_BITS      = HI_BITS + COUNT_BITS + 2;
  localparam logic [RATE_BITS-1:0] RATE_RESET = 16'd3277;
  localparam logic signed [63:0] ONE_Q = 64'sd65536;

  typedef enum logic [1:0] {
    OP_LOAD_W  = 2'd0,
    OP_TRAIN   = 2'd1,
    OP_PREDICT = 2'd2,
    OP_LOAD_B  = 2'd3
  } op_e;

  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_TRAIN   = 1'b1;

  typedef struct packed {
    op_e                     operation;
    logic [COUNT_BITS-1:0]   feature_count;
    logic signed [31:0]      weight_value;
    logic                    label;
    logic                    last;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic               predicted_class;
    logic signed [31:0] score;
    logic signed [31:0] error_value;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_ACC,
    ST_FINISH,
    ST_RATE,
    ST_BIAS,
    ST_UPD_RD,
    ST_UPD_MUL,
    ST_UPD_WR
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    hi_lim = 64'sd2147483647;
    lo_lim = -64'sd2147483648;
    if (x > hi_lim) sat32 = 32'sh7fffffff;
    else if (x < lo_lim) sat32 = 32'sh80000000;
    else sat32 = x[31:0];
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat48(input logic signed [63:0] x);
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    hi_lim = (64'sd1 <<< (ACC_BITS - 1)) - 64'sd1;
    lo_lim = -(64'sd1 <<< (ACC_BITS - 1));
    if (x > hi_lim) sat48 = hi_lim[ACC_BITS-1:0];
    else if (x < lo_lim) sat48 = lo_lim[ACC_BITS-1:0];
    else sat48 = x[ACC_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/lcdr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module lcdr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/lcdr_step.sv */
`timescale 1ns / 1ps
`default_nettype none
module lcdr_step (
  input  wire logic                                   clk_i,
  input  wire logic                                   en_i,
  input  wire logic signed [lcdr_pkg::HI_BITS-1:0]    hi_i,
  input  wire logic [lcdr_pkg::FRAC_BITS-1:0]         lo_i,
  input  wire logic [lcdr_pkg::COUNT_BITS-1:0]        count_i,
  output logic signed [lcdr_pkg::TERM_BITS-1:0]       term_o
);
  import lcdr_pkg::*;

  localparam int unsigned LOP_BITS = FRAC_BITS + COUNT_BITS + 1;

  logic signed [HI_BITS+COUNT_BITS:0] hi_prod;
  logic [LOP_BITS-1:0]                lo_prod;
  logic [COUNT_BITS:0]                rnd;

  // step = hi*count + round-half-up of the fractional part times count
  always_comb begin
    hi_prod = hi_i * $signed({1'b0, count_i});
    lo_prod = LOP_BITS'(lo_i) * LOP_BITS'(count_i) + LOP_BITS'(1 << (FRAC_BITS - 1));
    rnd     = lo_prod[LOP_BITS-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) term_o <= TERM_BITS'(hi_prod) + $signed(TERM_BITS'({1'b0, rnd}));
  end

endmodule
`default_nettype wire

/* rtl/linear_classifier_delta_rule_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Load weight and load bias items are taken in ST_IDLE, which they do not leave.
// A train or predict element passes weight read (ST_IDLE), multiply (ST_FETCH) and
// accumulate (ST_ACC); a last element then goes to ST_FINISH. A train vector also
// runs an update pass: ST_RATE, ST_BIAS, then ST_UPD_RD, ST_UPD_MUL, ST_UPD_WR per
// element. Reset clears control state, then all N_WORDS weight memory entries are
// zeroed, one a cycle, while no item is accepted; config writes are always taken.
module linear_classifier_delta_rule_top #(
  parameter int unsigned N_WORDS = lcdr_pkg::N_WORDS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire lcdr_pkg::in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output lcdr_pkg::out_t                        out_data_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [lcdr_pkg::RATE_BITS-1:0]   cfg_data_i
);
  import lcdr_pkg::*;

  localparam int unsigned AW = $clog2(N_WORDS);
  localparam int unsigned PW = $clog2(N_WORDS + 1);
  localparam logic [PW-1:0] POS_END = PW'(N_WORDS);
  localparam logic [AW-1:0] ADDR_LAST = AW'(N_WORDS - 1);

  state_e                       state_q, state_d;
  logic [PW-1:0]                pos_q, pos_d;
  logic [PW-1:0]                upd_idx_q, upd_idx_d;
  logic [PW-1:0]                upd_end_q, upd_end_d;
  logic [AW-1:0]                clr_q, clr_d;
  logic signed [ACC_BITS-1:0]   acc_q, acc_d;
  logic signed [31:0]           bias_q, bias_d;
  logic [RATE_BITS-1:0]         rate_q, rate_d;
  op_e                          op_q, op_d;
  logic                         label_q, label_d;
  logic                         last_q, last_d;
  logic [COUNT_BITS-1:0]        cnt_q, cnt_d;
  logic signed [EPROD_BITS-1:0] eprod_q, eprod_d;
  logic signed [31:0]           err_q, err_d;
  logic signed [UPROD_BITS-1:0] uprod_q, uprod_d;
  logic                         out_valid_q, out_valid_d;
  out_t                         out_q, out_d;

  logic                         w_we, w_re, c_we, c_re;
  logic [AW-1:0]                w_waddr, w_raddr, c_raddr;
  logic [31:0]                  w_wdata, w_rdata;
  logic [COUNT_BITS-1:0]        c_rdata;
  logic signed [TERM_BITS-1:0]  term;
  logic                         step_en;
  logic                         accept, res_load, in_range;
  logic signed [31:0]           score, err;
  logic signed [HI_BITS-1:0]    hi;

  lcdr_ram #(.WIDTH(32), .DEPTH(N_WORDS)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  lcdr_ram #(.WIDTH(COUNT_BITS), .DEPTH(N_WORDS)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (pos_q[AW-1:0]),
    .wdata_i (in_data_i.feature_count),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  lcdr_step u_step (
    .clk_i   (clk_i),
    .en_i    (step_en),
    .hi_i    (hi),
    .lo_i    (uprod_q[FRAC_BITS-1:0]),
    .count_i (c_rdata),
    .term_o  (term)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_range    = (pos_q < POS_END);
  assign hi          = uprod_q[UPROD_BITS-1:FRAC_BITS];

  always_comb begin
    score = sat32(64'(acc_q));
    err   = sat32((label_q ? ONE_Q : 64'sd0) - 64'(score));
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    upd_idx_d   = upd_idx_q;
    upd_end_d   = upd_end_q;
    clr_d       = clr_q;
    acc_d       = acc_q;
    bias_d      = bias_q;
    rate_d      = rate_q;
    op_d        = op_q;
    label_d     = label_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    eprod_d     = eprod_q;
    err_d       = err_q;
    uprod_d     = uprod_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    w_we        = 1'b0;
    w_waddr     = pos_q[AW-1:0];
    w_wdata     = in_data_i.weight_value;
    w_re        = 1'b0;
    w_raddr     = pos_q[AW-1:0];
    c_we        = 1'b0;
    c_re        = 1'b0;
    c_raddr     = upd_idx_q[AW-1:0];
    step_en     = 1'b0;
    res_load    = 1'b0;

    if (cfg_valid_i) rate_d = cfg_data_i;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = clr_q;
        w_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == ADDR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.operation)
            OP_LOAD_B: bias_d = in_data_i.weight_value;
            OP_LOAD_W: begin
              if (in_range) begin
                w_we  = 1'b1;
                pos_d = pos_q + 1'b1;
              end
              if (in_data_i.last) pos_d = '0;
            end
            default: begin
              op_d    = in_data_i.operation;
              label_d = in_data_i.label;
              last_d  = in_data_i.last;
              cnt_d   = in_data_i.feature_count;
              if (pos_q == '0) acc_d = ACC_BITS'(bias_q);
              if (in_range) begin
                w_re    = 1'b1;
                c_we    = 1'b1;
                pos_d   = pos_q + 1'b1;
                state_d = ST_FETCH;
              end else if (in_data_i.last) begin
                state_d = ST_FINISH;
              end
            end
          endcase
        end
      end
      ST_FETCH: begin
        eprod_d = $signed(w_rdata) * $signed({1'b0, cnt_q});
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d   = sat48(64'(acc_q) + 64'(eprod_q));
        state_d = last_q ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          res_load                = 1'b1;
          out_valid_d             = 1'b1;
          out_d.score             = score;
          out_d.predicted_class   = (score > 32'sd0);
          out_d.result_kind       = (op_q == OP_TRAIN) ? KIND_TRAIN : KIND_PREDICT;
          out_d.error_value       = (op_q == OP_TRAIN) ? err : 32'sd0;
          err_d                   = err;
          upd_end_d               = pos_q;
          pos_d                   = '0;
          state_d                 = (op_q == OP_TRAIN) ? ST_RATE : ST_IDLE;
        end
      end
      ST_RATE: begin
        uprod_d = $signed({1'b0, rate_q}) * err_q;
        state_d = ST_BIAS;
      end
      ST_BIAS: begin
        // count of one: the rounding carry is the top fraction bit
        bias_d    = sat32(64'(bias_q) + 64'(hi) + 64'(uprod_q[FRAC_BITS-1]));
        upd_idx_d = '0;
        state_d   = (upd_end_q == '0) ? ST_IDLE : ST_UPD_RD;
      end
      ST_UPD_RD: begin
        w_re    = 1'b1;
        w_raddr = upd_idx_q[AW-1:0];
        c_re    = 1'b1;
        state_d = ST_UPD_MUL;
      end
      ST_UPD_MUL: begin
        step_en = 1'b1;
        state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        w_we      = 1'b1;
        w_waddr   = upd_idx_q[AW-1:0];
        w_wdata   = sat32(64'($signed(w_rdata)) + 64'(term));
        upd_idx_d = upd_idx_q + 1'b1;
        state_d   = (upd_idx_d == upd_end_q) ? ST_IDLE : ST_UPD_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pos_q       <= '0;
      clr_q       <= '0;
      acc_q       <= '0;
      bias_q      <= '0;
      rate_q      <= RATE_RESET;
      out_valid_q <= 1'b0;
      upd_idx_q   <= '0;
      upd_end_q   <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      clr_q       <= clr_d;
      acc_q       <= acc_d;
      bias_q      <= bias_d;
      rate_q      <= rate_d;
      out_valid_q <= out_valid_d;
      upd_idx_q   <= upd_idx_d;
      upd_end_q   <= upd_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    label_q <= label_d;
    last_q  <= last_d;
    cnt_q   <= cnt_d;
    eprod_q <= eprod_d;
    err_q   <= err_d;
    uprod_q <= uprod_d;
    out_q   <= out_d;
  end

`ifndef SYNTH
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (w_we && w_wdata == '0))
    else $error("clearing pass wrote a non-zero weight");

  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transfer");

  a_upd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_WR) |-> (upd_idx_q < upd_end_q && upd_end_q <= POS_END))
    else $error("update pass beyond the vector");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_END)
    else $error("position beyond the vocabulary");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_WR && upd_idx_d != upd_end_q) |=> !in_ready_o)
    else $error("item taken during the update pass");
`endif

endmodule
`default_nettype wire

/* test/tb_linear_classifier_delta_rule_top.sv */
`timescale 1ns / 1ps
module tb_linear_classifier_delta_rule_top;
  import lcdr_pkg::*;

  localparam int VOCAB = 1024;
  localparam longint W_HI = 64'sd2147483647;
  localparam longint W_LO = -64'sd2147483648;
  localparam longint A_HI = (64'sd1 <<< 47) - 1;
  localparam longint A_LO = -(64'sd1 <<< 47);
  localparam longint T_LIM = 64'sd1 <<< 50;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 3300;

  class classifier_scoreboard;
    longint weights[VOCAB];
    longint bias;
    longint acc;
    int unsigned counts[VOCAB];
    bit count_seen[VOCAB];
    int unsigned pos;
    int unsigned rate;
    out_t pending[$];
    int errors, trains, predicts;

    function new();
      foreach (weights[i]) begin
        weights[i] = 0;
        counts[i] = 0;
        count_seen[i] = 0;
      end
      bias = 0;
      acc = 0;
      pos = 0;
      rate = 3277;
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // value + round(prod * count / 2^16), saturated to the weight width
    function longint stepped(longint value, longint prod, longint cnt);
      longint hi_part, lo_part, term;
      hi_part = prod >>> 16;
      lo_part = prod & 64'hFFFF;
      term = clip(hi_part * cnt, -T_LIM, T_LIM);
      term += (lo_part * cnt + 64'sd32768) >>> 16;
      return clip(value + term, W_LO, W_HI);
    endfunction

    // a train vector may only end once every count it will reread exists
    function bit may_end_train();
      for (int i = 0; i < pos; i++) if (!count_seen[i]) return 0;
      return 1;
    endfunction

    function void note_input(in_t it);
      longint wv, score, err, prod;
      int unsigned n;
      out_t res;
      wv = longint'(it.weight_value);
      case (it.operation)
        OP_LOAD_B: bias = wv;
        OP_LOAD_W: begin
          if (pos < VOCAB) begin
            weights[pos] = wv;
            pos++;
          end
          if (it.last) pos = 0;
        end
        default: begin
          if (pos == 0) acc = bias;
          if (pos < VOCAB) begin
            counts[pos] = 32'(it.feature_count);
            count_seen[pos] = 1;
            acc = clip(acc + clip(weights[pos] * longint'(it.feature_count), -T_LIM, T_LIM),
                       A_LO, A_HI);
            pos++;
          end
          if (it.last) begin
            n = pos;
            pos = 0;
            score = clip(acc, W_LO, W_HI);
            res.result_kind = (it.operation == OP_TRAIN) ? KIND_TRAIN : KIND_PREDICT;
            res.predicted_class = score > 0;
            res.score = score[31:0];
            res.error_value = '0;
            if (it.operation == OP_TRAIN) begin
              err = clip((it.label ? 64'sd65536 : 64'sd0) - score, W_LO, W_HI);
              prod = longint'(rate) * err;
              bias = stepped(bias, prod, 64'sd1);
              for (int i = 0; i < n; i++)
                weights[i] = stepped(weights[i], prod, longint'(counts[i]));
              res.error_value = err[31:0];
              trains++;
            end else begin
              predicts++;
            end
            pending.push_back(res);
          end
        end
      endcase
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        $error("result with nothing outstanding: %p", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.result_kind !== exp_r.result_kind) begin
        $error("result_kind exp %0d got %0d", exp_r.result_kind, got.result_kind);
        errors++;
      end
      if (got.predicted_class !== exp_r.predicted_class) begin
        $error("predicted_class exp %0d got %0d", exp_r.predicted_class, got.predicted_class);
        errors++;
      end
      if (got.score !== exp_r.score) begin
        $error("score exp %0d got %0d", exp_r.score, got.score);
        errors++;
      end
      if (got.error_value !== exp_r.error_value) begin
        $error("error_value exp %0d got %0d", exp_r.error_value, got.error_value);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [RATE_BITS-1:0] cfg_data_i = '0;

  classifier_scoreboard sb = new();
  bit no_gaps = 1'b0;
  int idle_cycles = 0;
  int items_sent = 0;

  linear_classifier_delta_rule_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // sample mid-cycle: these values are the ones taken at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (cfg_valid_i && cfg_ready_o) sb.rate = 32'(cfg_data_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 19);
  endfunction

  // result side: stall a random number of cycles before each transfer
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send(in_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // hold the end of a train vector back if it would reread unknown counts
    if (it.operation == OP_TRAIN && it.last && !sb.may_end_train()) it.last = 1'b0;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  function in_t make_item(op_e op, logic [7:0] cnt, logic [31:0] wv, bit lbl, bit lst);
    in_t it;
    it.operation = op;
    it.feature_count = cnt;
    it.weight_value = wv;
    it.label = lbl;
    it.last = lst;
    return it;
  endfunction

  function logic [31:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'(int'($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  function logic [7:0] rand_count();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 12));
    endcase
  endfunction

  task automatic send_vector(op_e op, int len, bit lbl, bit mix_loads);
    op_e eop;
    for (int i = 0; i < len; i++) begin
      eop = op;
      if (mix_loads && i != len - 1 && $urandom_range(0, 4) == 0)
        eop = op_e'($urandom_range(0, 2));
      send(make_item(eop, rand_count(), rand_weight(), lbl, i == len - 1));
    end
  endtask

  task automatic send_weights(int len);
    for (int i = 0; i < len; i++)
      send(make_item(OP_LOAD_W, 8'($urandom()), rand_weight(), 1'($urandom_range(0, 1)),
                     i == len - 1));
  endtask

  // pause input until every result is back, then let the update pass settle
  task automatic write_rate(logic [RATE_BITS-1:0] r);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state, extremes, each operation
    send(make_item(OP_PREDICT, 8'd255, 32'h0, 1'b0, 1'b1));
    send(make_item(OP_LOAD_W, 8'd0, 32'h7fffffff, 1'b0, 1'b0));
    send(make_item(OP_LOAD_W, 8'd0, 32'h80000000, 1'b0, 1'b0));
    send(make_item(OP_LOAD_W, 8'd0, 32'h00010000, 1'b0, 1'b1));
    send(make_item(OP_PREDICT, 8'd255, 32'h0, 1'b0, 1'b0));
    send(make_item(OP_PREDICT, 8'd0, 32'h0, 1'b0, 1'b1));
    send(make_item(OP_TRAIN, 8'd255, 32'hffffffff, 1'b1, 1'b0));
    send(make_item(OP_TRAIN, 8'd255, 32'h0, 1'b1, 1'b0));
    send(make_item(OP_TRAIN, 8'd1, 32'h0, 1'b1, 1'b1));
    send(make_item(OP_LOAD_B, 8'd255, 32'h80000000, 1'b1, 1'b1));
    send(make_item(OP_TRAIN, 8'd0, 32'h0, 1'b0, 1'b1));
    send(make_item(OP_LOAD_B, 8'd0, 32'h00030000, 1'b0, 1'b0));
    send(make_item(OP_PREDICT, 8'd2, 32'h0, 1'b0, 1'b1));
    send(make_item(OP_TRAIN, 8'd3, 32'h0, 1'b0, 1'b1));
    write_rate(16'hffff);
    send(make_item(OP_TRAIN, 8'd255, 32'h0, 1'b1, 1'b0));
    send(make_item(OP_TRAIN, 8'd7, 32'h0, 1'b1, 1'b1));
    write_rate(16'h0000);
    send(make_item(OP_TRAIN, 8'd9, 32'h0, 1'b0, 1'b1));
    send(make_item(OP_PREDICT, 8'd9, 32'h0, 1'b0, 1'b1));

    // random phases, each with its own rate
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_rate(16'd3277);
        1: write_rate(16'hffff);
        2: write_rate(16'd1);
        default: write_rate(16'($urandom()));
      endcase
      // one phase runs a vector past the vocabulary end
      if (ph == 2) begin
        no_gaps = 1'b1;
        send_vector(OP_TRAIN, VOCAB + 3, 1'b1, 1'b0);
        no_gaps = 1'b0;
      end
      while (items_sent < 25 * (ph + 1) + 20 + ((ph >= 2) ? VOCAB + 3 : 0)) begin
        if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
        pick = $urandom_range(0, 19);
        if (pick < 3) send_weights($urandom_range(1, 6));
        else if (pick < 4) send(make_item(OP_LOAD_B, 8'($urandom()), rand_weight(),
                                          1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1))));
        else if (pick < 11) send_vector(OP_TRAIN, $urandom_range(1, 8),
                                        1'($urandom_range(0, 1)),
                                        $urandom_range(0, 3) == 0);
        else if (pick < 17) send_vector(OP_PREDICT, $urandom_range(1, 8), 1'b0,
                                        $urandom_range(0, 3) == 0);
        else send(make_item(op_e'($urandom_range(0, 3)), 8'($urandom()), $urandom(),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end
    end

    // close any open vector so its result is counted
    if (sb.pos != 0) send(make_item(OP_PREDICT, 8'd1, 32'h0, 1'b0, 1'b1));
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d items over seven learning rates; checked %0d train and %0d predict results",
             items_sent, sb.trains, sb.predicts);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
